// ===== rtl/kwm_pkg.sv =====
package kwm_pkg;

  // Request and result payloads
  typedef struct packed {
    logic        mode;
    logic [3:0]  run_index;
    logic [63:0] value;
    logic        run_empty;
  } kwm_req_t;

  typedef struct packed {
    logic [63:0] min_value;
    logic [3:0]  min_run;
    logic        done_res;
  } kwm_rsp_t;

  // Request modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REPLACE = 1'b1;

  // Register word indexes
  localparam logic REG_NUM_RUNS = 1'b0;

  localparam logic [4:0] NUM_RUNS_RESET = 5'd16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_GRAB,
    ST_CHILD,
    ST_CMP,
    ST_EMIT
  } kwm_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic replace;
    logic fetch;
    logic grab;
    logic child;
    logic cmp;
  } kwm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic merging;
    logic load_last;
    logic root_exh;
    logic sift_stop;
    logic build_more;
  } kwm_stat_t;

endpackage

// ===== rtl/kwm_ctrl.sv =====
module kwm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               mode,
  input  kwm_pkg::kwm_stat_t stat,
  output kwm_pkg::kwm_cmd_t  cmd,
  output logic               busy,
  output logic               valid
);

  kwm_pkg::kwm_state_t state, state_next;

  logic take_load;
  logic take_replace;

  // Decode an accepted request against the current phase
  assign take_load    = (state == kwm_pkg::ST_IDLE) && start && !stat.merging &&
                        (mode == kwm_pkg::MODE_LOAD);
  assign take_replace = (state == kwm_pkg::ST_IDLE) && start && stat.merging &&
                        (mode == kwm_pkg::MODE_REPLACE);

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kwm_pkg::ST_IDLE: begin
        if (take_load && stat.load_last) begin
          state_next = kwm_pkg::ST_FETCH;
        end else if (take_replace) begin
          state_next = stat.root_exh ? kwm_pkg::ST_EMIT : kwm_pkg::ST_CHILD;
        end
      end
      kwm_pkg::ST_FETCH: state_next = kwm_pkg::ST_GRAB;
      kwm_pkg::ST_GRAB:  state_next = kwm_pkg::ST_CMP;
      kwm_pkg::ST_CHILD: state_next = kwm_pkg::ST_CMP;
      kwm_pkg::ST_CMP: begin
        if (!stat.sift_stop) begin
          state_next = kwm_pkg::ST_CHILD;
        end else if (stat.build_more) begin
          state_next = kwm_pkg::ST_FETCH;
        end else begin
          state_next = kwm_pkg::ST_EMIT;
        end
      end
      kwm_pkg::ST_EMIT:  state_next = kwm_pkg::ST_IDLE;
      default:           state_next = kwm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    busy        = 1'b1;
    valid       = 1'b0;
    case (state)
      kwm_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = take_load;
        cmd.replace = take_replace && !stat.root_exh;
      end
      kwm_pkg::ST_FETCH: cmd.fetch = 1'b1;
      kwm_pkg::ST_GRAB:  cmd.grab  = 1'b1;
      kwm_pkg::ST_CHILD: cmd.child = 1'b1;
      kwm_pkg::ST_CMP:   cmd.cmp   = 1'b1;
      kwm_pkg::ST_EMIT:  valid     = 1'b1;
      default:           busy      = 1'b0;
    endcase
  end

endmodule

// ===== rtl/kwm_dp.sv =====
module kwm_dp #(
  parameter int MAX_RUNS     = 16,
  parameter int ELEMENT_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  kwm_pkg::kwm_cmd_t  cmd,
  input  kwm_pkg::kwm_req_t  req,
  input  logic [4:0]         num_runs,
  output kwm_pkg::kwm_stat_t stat,
  output kwm_pkg::kwm_rsp_t  rsp
);

  localparam int IW    = $clog2(MAX_RUNS);
  localparam int CW    = $clog2(MAX_RUNS + 1);
  localparam int XW    = IW + 2;
  localparam int NW    = (CW > 5) ? CW : 5;
  localparam int DEPTH = 1 << IW;
  localparam int EW    = ELEMENT_BITS;

  // Heap storage
  logic [EW-1:0] mem_val [DEPTH];
  logic [3:0]    mem_run [DEPTH];
  logic          mem_exh [DEPTH];

  logic [EW-1:0] rd0_val, rd1_val, cur_val, root_val, wd_val, child_val;
  logic [3:0]    rd0_run, rd1_run, cur_run, root_run, wd_run, child_run;
  logic          rd0_exh, rd1_exh, cur_exh, root_exh, wd_exh, child_exh;

  logic [IW-1:0] pos, bidx, ra0, ra1, wa, bidx_dec;
  logic [CW-1:0] cnt, size;
  logic          merging, building;
  logic          we;

  logic [NW-1:0] n_req, n_eff, cnt_inc;
  logic          load_last;

  logic [XW-1:0] lidx, ridx, best;
  logic          l_in, r_in, l_wins, r_wins, stop;

  // Clamp the run count to the heap capacity; zero counts as one
  always_comb begin
    n_req = NW'(num_runs);
    if (n_req == '0) begin
      n_eff = NW'(1);
    end else if (n_req > NW'(MAX_RUNS)) begin
      n_eff = NW'(MAX_RUNS);
    end else begin
      n_eff = n_req;
    end
    cnt_inc   = NW'(cnt) + NW'(1);
    load_last = (cnt_inc >= n_eff);
  end

  // Child positions and bounds
  assign lidx = {1'b0, pos, 1'b1};
  assign ridx = lidx + XW'(1);
  assign l_in = (lidx < XW'(size));
  assign r_in = (ridx < XW'(size));

  // Pick the smallest of current entry and children; exhausted sorts last
  always_comb begin
    l_wins = l_in && !rd0_exh && (cur_exh || (rd0_val < cur_val));
    if (l_wins) begin
      r_wins = r_in && !rd1_exh && (rd1_val < rd0_val);
    end else begin
      r_wins = r_in && !rd1_exh && (cur_exh || (rd1_val < cur_val));
    end
    stop      = !l_wins && !r_wins;
    best      = r_wins ? ridx : lidx;
    child_val = r_wins ? rd1_val : rd0_val;
    child_run = r_wins ? rd1_run : rd0_run;
    child_exh = r_wins ? rd1_exh : rd0_exh;
  end

  // Read and write addresses
  assign ra0      = cmd.fetch ? pos : lidx[IW-1:0];
  assign ra1      = ridx[IW-1:0];
  assign we       = cmd.load || cmd.cmp;
  assign wa       = cmd.load ? cnt[IW-1:0] : pos;
  assign bidx_dec = bidx - IW'(1);

  always_comb begin
    if (cmd.load) begin
      wd_val = req.value[EW-1:0];
      wd_run = req.run_index;
      wd_exh = req.run_empty;
    end else if (stop) begin
      wd_val = cur_val;
      wd_run = cur_run;
      wd_exh = cur_exh;
    end else begin
      wd_val = child_val;
      wd_run = child_run;
      wd_exh = child_exh;
    end
  end

  // Memory ports; hold read data through the compare cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[wa] <= wd_val;
      mem_run[wa] <= wd_run;
      mem_exh[wa] <= wd_exh;
    end
    if (cmd.fetch || cmd.grab || cmd.child) begin
      rd0_val <= mem_val[ra0];
      rd0_run <= mem_run[ra0];
      rd0_exh <= mem_exh[ra0];
      rd1_val <= mem_val[ra1];
      rd1_run <= mem_run[ra1];
      rd1_exh <= mem_exh[ra1];
    end
  end

  // Phase and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      merging  <= 1'b0;
      building <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= cnt + CW'(1);
        if (load_last) begin
          merging  <= 1'b1;
          building <= 1'b1;
        end
      end
      if (cmd.replace) begin
        building <= 1'b0;
      end
    end
  end

  // Sift position, build index, sifting entry and root copy
  always_ff @(posedge clk) begin
    if (cmd.load && load_last) begin
      size <= CW'(cnt_inc);
      bidx <= IW'(cnt >> 1);
      pos  <= IW'(cnt >> 1);
    end
    if (cmd.replace) begin
      cur_val <= req.value[EW-1:0];
      cur_run <= root_run;
      cur_exh <= req.run_empty;
      pos     <= '0;
    end
    if (cmd.grab) begin
      cur_val <= rd0_val;
      cur_run <= rd0_run;
      cur_exh <= rd0_exh;
    end
    if (cmd.cmp) begin
      if (!stop) begin
        pos <= best[IW-1:0];
      end else if (building && (bidx != '0)) begin
        bidx <= bidx_dec;
        pos  <= bidx_dec;
      end
    end
    if (we && (wa == '0)) begin
      root_val <= wd_val;
      root_run <= wd_run;
      root_exh <= wd_exh;
    end
  end

  // Status
  assign stat.merging    = merging;
  assign stat.load_last  = load_last;
  assign stat.root_exh   = root_exh;
  assign stat.sift_stop  = stop;
  assign stat.build_more = building && (bidx != '0);

  // Result from the root
  assign rsp.min_value = root_exh ? 64'd0 : 64'(root_val);
  assign rsp.min_run   = root_exh ? 4'd0 : root_run;
  assign rsp.done_res  = root_exh;

endmodule

// ===== rtl/k_way_merge_min_heap.sv =====
// Load request: taken while idle; the last load builds the heap, a fetch, grab and
//   compare per node from (N-1)/2 down to the root plus a read and compare per level
//   it sinks, then the minimum. Replace request: result after a read and compare per
//   heap level visited (1 to floor(log2(N))+1, none once all runs are exhausted).
// Next request is taken the cycle after the result; the receiver cannot stall.
// Reset clears the controller, fill count and phase; num_runs returns to 16.
module k_way_merge_min_heap #(
  parameter int MAX_RUNS     = 16,
  parameter int ELEMENT_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kwm_pkg::kwm_req_t req,
  output logic              valid,
  output kwm_pkg::kwm_rsp_t rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  kwm_pkg::kwm_cmd_t  cmd;
  kwm_pkg::kwm_stat_t stat;
  logic [4:0]         num_runs;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == kwm_pkg::REG_NUM_RUNS) ? {27'd0, num_runs} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_runs <= kwm_pkg::NUM_RUNS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == kwm_pkg::REG_NUM_RUNS)) begin
      num_runs <= pwdata[4:0];
    end
  end

  kwm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (req.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .valid (valid)
  );

  kwm_dp #(
    .MAX_RUNS     (MAX_RUNS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .num_runs (num_runs),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule

// ===== rtl/kwm_chk.sv =====
module kwm_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input kwm_pkg::kwm_req_t req,
  input logic              valid,
  input kwm_pkg::kwm_rsp_t rsp
);

  // A result is only shown while a request is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result strobe while idle");

  // The block frees up right after a result
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    valid |=> !busy) else $error("still busy after result");

  // A done result carries no element
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && rsp.done_res) |-> ((rsp.min_value == 64'd0) && (rsp.min_run == 4'd0)))
    else $error("done result with payload");

  // Reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !valid)) else $error("not idle after reset");

  // A load request taken while idle cannot produce a result in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.mode == kwm_pkg::MODE_LOAD)) |=> !valid)
    else $error("result too early");

endmodule

bind k_way_merge_min_heap kwm_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .valid (valid),
  .rsp   (rsp)
);

// ===== tb/k_way_merge_min_heap_tb.sv =====
module k_way_merge_min_heap_tb;

  localparam int          HEAP_SLOTS    = 16;
  localparam int          RANDOM_ITEMS  = 1080;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          STALL_LIMIT   = 1000;
  localparam logic [2:0]  NUM_RUNS_ADDR = {kwm_pkg::REG_NUM_RUNS, 2'b00};

  // Heap predictor plus the queue of minimums still owed by the block
  class merge_scoreboard;
    logic [63:0]       slot_value [HEAP_SLOTS];
    logic [3:0]        slot_run   [HEAP_SLOTS];
    bit                slot_gone  [HEAP_SLOTS];
    int unsigned       loaded;
    int unsigned       finished;
    int unsigned       heap_len;
    bit                merging;
    logic [4:0]        num_runs;
    logic [63:0]       last_value;
    int unsigned       errors;
    kwm_pkg::kwm_rsp_t owed_q [$];

    function new();
      foreach (slot_gone[i]) begin
        slot_value[i] = '0;
        slot_run[i]   = '0;
        slot_gone[i]  = 1'b0;
      end
      loaded     = 0;
      finished   = 0;
      heap_len   = 0;
      merging    = 1'b0;
      num_runs   = kwm_pkg::NUM_RUNS_RESET;
      last_value = '0;
      errors     = 0;
    endfunction

    // An exhausted entry sorts after every live one
    function bit ranks_first(int unsigned a, int unsigned b);
      if (slot_gone[a]) return 1'b0;
      if (slot_gone[b]) return 1'b1;
      return slot_value[a] < slot_value[b];
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [63:0] v;
      logic [3:0]  r;
      bit          g;
      v = slot_value[a]; r = slot_run[a]; g = slot_gone[a];
      slot_value[a] = slot_value[b];
      slot_run[a]   = slot_run[b];
      slot_gone[a]  = slot_gone[b];
      slot_value[b] = v; slot_run[b] = r; slot_gone[b] = g;
    endfunction

    // Sink an entry until neither child orders strictly before it
    function void sink(int unsigned pos);
      int unsigned l;
      int unsigned r;
      int unsigned best;
      while (1'b1) begin
        l = 2 * pos + 1;
        r = l + 1;
        best = pos;
        if (l < heap_len && ranks_first(l, best)) best = l;
        if (r < heap_len && ranks_first(r, best)) best = r;
        if (best == pos) return;
        swap_slots(pos, best);
        pos = best;
      end
    endfunction

    // Owe the current root, or a done result once every run is exhausted
    function void owe_root();
      kwm_pkg::kwm_rsp_t e;
      e = '0;
      if (heap_len == 0 || slot_gone[0]) begin
        e.done_res = 1'b1;
      end else begin
        e.min_value = slot_value[0];
        e.min_run   = slot_run[0];
        last_value  = slot_value[0];
      end
      owed_q.push_back(e);
    endfunction

    function void note_request(kwm_pkg::kwm_req_t r);
      int unsigned limit;
      int unsigned i;
      limit = (num_runs == 0) ? 1 : ((num_runs > HEAP_SLOTS) ? HEAP_SLOTS : num_runs);
      if (!merging) begin
        // drop replaces until the heap exists
        if (r.mode != kwm_pkg::MODE_LOAD || loaded >= HEAP_SLOTS) return;
        slot_value[loaded] = r.value;
        slot_run[loaded]   = r.run_index;
        slot_gone[loaded]  = r.run_empty;
        if (r.run_empty) finished++;
        loaded++;
        if (loaded < limit) return;
        heap_len = loaded;
        merging  = 1'b1;
        for (i = (heap_len - 1) / 2 + 1; i > 0; i--) sink(i - 1);
        owe_root();
        return;
      end
      // drop loads once merging
      if (r.mode != kwm_pkg::MODE_REPLACE) return;
      if (heap_len != 0 && !slot_gone[0]) begin
        slot_value[0] = r.value;
        slot_gone[0]  = r.run_empty;
        if (r.run_empty) finished++;
        sink(0);
      end
      owe_root();
    endfunction

    function void check_result(kwm_pkg::kwm_rsp_t got);
      kwm_pkg::kwm_rsp_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result value=%h run=%0d done=%0b", $time,
                 got.min_value, got.min_run, got.done_res);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got.min_value !== e.min_value) begin
        $display("%0t: min_value expected %h actual %h", $time, e.min_value, got.min_value);
        errors++;
      end
      if (got.min_run !== e.min_run) begin
        $display("%0t: min_run expected %0d actual %0d", $time, e.min_run, got.min_run);
        errors++;
      end
      if (got.done_res !== e.done_res) begin
        $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, got.done_res);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function int unsigned live_runs();
      return heap_len - finished;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  kwm_pkg::kwm_req_t req;
  logic              valid;
  kwm_pkg::kwm_rsp_t rsp;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int unsigned       idle_cycles;

  merge_scoreboard sb = new();

  k_way_merge_min_heap i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .valid   (valid),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every strobed result against the oldest owed minimum
  always @(posedge clk) begin
    if (!rst && valid) sb.check_result(rsp);
  end

  // Count cycles with no request, result or register access
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("k_way_merge_min_heap_tb: FAIL");
    $finish;
  end

  function automatic kwm_pkg::kwm_req_t load_req(logic [3:0] run, logic [63:0] v,
                                                 logic empty);
    kwm_pkg::kwm_req_t r;
    r.mode      = kwm_pkg::MODE_LOAD;
    r.run_index = run;
    r.value     = v;
    r.run_empty = empty;
    return r;
  endfunction

  function automatic kwm_pkg::kwm_req_t replace_req(logic [63:0] v, logic empty);
    kwm_pkg::kwm_req_t r;
    r.mode      = kwm_pkg::MODE_REPLACE;
    r.run_index = 4'($urandom_range(0, 15));
    r.value     = v;
    r.run_empty = empty;
    return r;
  endfunction

  // Mostly a sorted continuation of the last minimum, sometimes anything
  function automatic logic [63:0] next_element();
    logic [63:0] step;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    step = 64'($urandom) >> $urandom_range(0, 31);
    case (pick)
      0: return {$urandom, $urandom};
      1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      2: return sb.last_value;
      default: return (sb.last_value > ~step) ? '1 : sb.last_value + step;
    endcase
  endfunction

  // Keep most runs alive until the tail, then exhaust them all
  function automatic logic run_ends(int unsigned remaining);
    if (remaining <= 24) return 1'b1;
    return sb.live_runs() > 3 && $urandom_range(0, 63) == 0;
  endfunction

  // Hold the request until the block takes it
  task automatic send(input kwm_pkg::kwm_req_t item);
    start = 1'b1;
    req   = item;
    do @(posedge clk); while (busy);
    sb.note_request(item);
    @(negedge clk);
  endtask

  // Drop start, wait out owed results and any work that gives none
  task automatic quiesce();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write num_runs, then read it back
  task automatic set_num_runs(input logic [4:0] count);
    logic [31:0] readback;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = NUM_RUNS_ADDR;
    pwdata  = {27'($urandom_range(0, 32'h07FF_FFFF)), count};
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.num_runs = count;
    @(negedge clk) begin
      pwrite  = 1'b0;
      penable = 1'b0;
    end
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk) begin
      psel    = 1'b0;
      penable = 1'b0;
    end
    if (readback[4:0] !== count) begin
      $display("%0t: num_runs readback expected %0d actual %0d", $time, count, readback[4:0]);
      sb.errors++;
    end
  endtask

  initial begin
    int unsigned remaining;
    int unsigned burst;
    int unsigned gap;
    rst     = 1'b1;
    start   = 1'b0;
    req     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Loading: out-of-range counts, ties, duplicate and empty runs
    set_num_runs(5'd31);
    send(replace_req({$urandom, $urandom}, 1'b0));
    send(load_req(4'd15, '1, 1'b0));
    send(load_req(4'd0, 64'd0, 1'b0));
    send(load_req(4'd3, 64'd5, 1'b1));
    send(load_req(4'd5, 64'd5, 1'b0));
    quiesce();
    set_num_runs(5'd17);
    send(load_req(4'd5, 64'd5, 1'b0));
    send(load_req(4'd8, 64'h8000_0000_0000_0000, 1'b0));
    send(load_req(4'd7, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
    send(load_req(4'd1, 64'd0, 1'b0));
    quiesce();
    set_num_runs(5'd16);
    for (int i = 0; i < 7; i++) send(load_req(4'(9 + i), {$urandom, $urandom}, 1'b0));
    quiesce();

    // Zero acts as one, so the next load builds the full heap
    set_num_runs(5'd0);
    send(load_req(4'd2, {$urandom, $urandom}, 1'b0));
    quiesce();

    // Merging: register writes and loads leave the heap alone
    set_num_runs(5'd1);
    send(load_req(4'd4, 64'd0, 1'b0));
    quiesce();
    set_num_runs(5'd16);
    send(replace_req(64'd0, 1'b0));
    send(replace_req('1, 1'b0));
    send(replace_req({$urandom, $urandom}, 1'b1));
    send(replace_req(sb.last_value, 1'b0));

    // Random merge traffic in bursts with gaps
    remaining = RANDOM_ITEMS;
    burst     = 0;
    while (remaining > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst--;
      if ($urandom_range(0, 15) == 0) begin
        send(load_req(4'($urandom_range(0, 15)), {$urandom, $urandom},
                      1'($urandom_range(0, 1))));
      end else begin
        send(replace_req(next_element(), run_ends(remaining)));
        remaining--;
      end
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("k_way_merge_min_heap_tb: PASS");
    end else begin
      $display("k_way_merge_min_heap_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kwm_pkg.sv
rtl/kwm_ctrl.sv
rtl/kwm_dp.sv
rtl/k_way_merge_min_heap.sv
rtl/kwm_chk.sv
tb/k_way_merge_min_heap_tb.sv
